// File: design/gnt_pkg.sv
// shared types and constants for the gradient noise turbulence block
`timescale 1ns / 1ps
`default_nettype none
package gnt_pkg;
   localparam int CoordFrac = 16;
   localparam int GradFrac = 14;
   localparam logic [1:0] CMD_LOAD_GRAD = 2'd0;
   localparam logic [1:0] CMD_LOAD_PERM = 2'd1;
   localparam logic [1:0] CMD_NOISE = 2'd2;
   localparam logic [1:0] CMD_TURB = 2'd3;
   localparam logic CSR_OCTAVE = 1'b0;
   localparam logic [3:0] OCTAVE_RESET = 4'd7;
   localparam logic [3:0] TOP_SHIFT = 4'd15;

   typedef struct packed {
      logic       first;
      logic       last;
      logic       zero;
      logic       absval;
      logic [3:0] shift;
   } ctl_type;

   typedef struct packed {
      logic        perm_wr;
      logic        grad_wr;
      logic [7:0]  index;
      logic [7:0]  perm_z;
      logic [7:0]  perm_y;
      logic [7:0]  perm_x;
      logic [15:0] grad_z;
      logic [15:0] grad_y;
      logic [15:0] grad_x;
   } wr_type;
endpackage
`default_nettype wire

// File: design/gnt_issue.sv
// command intake and octave sequencer
`timescale 1ns / 1ps
`default_nettype none
module gnt_issue import gnt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         command,
   input  wire logic signed [31:0] coord_x,
   input  wire logic signed [31:0] coord_y,
   input  wire logic signed [31:0] coord_z,
   input  wire logic [7:0]         table_index,
   input  wire logic signed [15:0] grad_x,
   input  wire logic signed [15:0] grad_y,
   input  wire logic signed [15:0] grad_z,
   input  wire logic [7:0]         perm_x,
   input  wire logic [7:0]         perm_y,
   input  wire logic [7:0]         perm_z,
   input  wire logic [3:0]         octave_count,
   output logic                    busy,
   output logic                    s0_valid,
   output ctl_type                 s0_ctl,
   output logic [2:0][31:0]        s0_coord,
   output wr_type                  s0_wr
);
   logic            valid_ff, valid_in;
   ctl_type         ctl_ff, ctl_in;
   logic [2:0][31:0] coord_ff, coord_in, next_ff, next_in;
   logic [3:0]      nshift_ff, nshift_in, remain_ff, remain_in;
   wr_type          wr_ff, wr_in;
   logic            accept, turb;

   assign busy = (remain_ff != 4'd0);
   assign accept = start & ~busy;
   assign turb = (command == CMD_TURB);

   always_comb begin
      valid_in = 1'b0;
      ctl_in = ctl_ff;
      coord_in = coord_ff;
      next_in = next_ff;
      nshift_in = nshift_ff;
      remain_in = remain_ff;
      wr_in = '0;
      if (accept) begin
         valid_in = (command == CMD_NOISE) || turb;
         ctl_in.first = 1'b1;
         ctl_in.last = !turb || (octave_count <= 4'd1);
         ctl_in.zero = turb && (octave_count == 4'd0);
         ctl_in.absval = turb;
         ctl_in.shift = TOP_SHIFT;
         coord_in = {coord_z, coord_y, coord_x};
         next_in = {coord_z << 1, coord_y << 1, coord_x << 1};
         nshift_in = TOP_SHIFT - 4'd1;
         remain_in = (turb && octave_count > 4'd1) ? octave_count - 4'd1 : 4'd0;
         wr_in.perm_wr = (command == CMD_LOAD_PERM);
         wr_in.grad_wr = (command == CMD_LOAD_GRAD);
         wr_in.index = table_index;
         wr_in.perm_x = perm_x;
         wr_in.perm_y = perm_y;
         wr_in.perm_z = perm_z;
         wr_in.grad_x = grad_x;
         wr_in.grad_y = grad_y;
         wr_in.grad_z = grad_z;
      end else if (busy) begin
         valid_in = 1'b1;
         ctl_in.first = 1'b0;
         ctl_in.last = (remain_ff == 4'd1);
         ctl_in.zero = 1'b0;
         ctl_in.absval = 1'b1;
         ctl_in.shift = nshift_ff;
         coord_in = next_ff;
         next_in = {next_ff[2] << 1, next_ff[1] << 1, next_ff[0] << 1};
         nshift_in = nshift_ff - 4'd1;
         remain_in = remain_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         remain_ff <= 4'd0;
         wr_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         remain_ff <= remain_in;
         wr_ff <= wr_in;
      end
      ctl_ff <= ctl_in;
      coord_ff <= coord_in;
      next_ff <= next_in;
      nshift_ff <= nshift_in;
   end

   assign s0_valid = valid_ff;
   assign s0_ctl = ctl_ff;
   assign s0_coord = coord_ff;
   assign s0_wr = wr_ff;
endmodule
`default_nettype wire

// File: design/gnt_fetch.sv
// lattice tables, corner gradient fetch and fade curve
`timescale 1ns / 1ps
`default_nettype none
module gnt_fetch import gnt_pkg::*; #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             s0_valid,
   input  wire ctl_type          s0_ctl,
   input  wire logic [2:0][31:0] s0_coord,
   input  wire wr_type           s0_wr,
   output logic                  s2_valid,
   output ctl_type               s2_ctl,
   output logic [2:0][15:0]      s2_frac,
   output logic [2:0][15:0]      s2_fade,
   output logic [7:0][47:0]      s2_grad
);
   localparam int IdxW = $clog2(TABLE_SIZE);
   localparam int PadW = (IdxW > 8) ? IdxW : 8;

   function automatic logic [IdxW-1:0] to_idx(input logic [7:0] v);
      logic [PadW-1:0] ext;
      ext = PadW'(v);
      return ext[IdxW-1:0];
   endfunction

   logic [7:0] perm_mem_ff [3][TABLE_SIZE];
   logic [IdxW-1:0] lo_idx [3];
   logic [IdxW-1:0] hi_idx [3];
   logic [IdxW-1:0] corner_idx [8];
   logic [2:0][7:0] perm_lo_ff, perm_hi_ff;
   logic [2:0][15:0] frac1_ff, f2_ff;
   logic [IdxW-1:0] widx;
   logic [7:0] wperm [3];
   logic        v1_ff, v2_ff;
   ctl_type     ctl1_ff, ctl2_ff;
   logic        gwr_ff;
   logic [IdxW-1:0] gidx_ff;
   logic [47:0] gdata_ff;
   logic [2:0][15:0] frac2_ff, fade_ff;
   logic [7:0][47:0] grad_ff;

   assign widx = to_idx(s0_wr.index);
   assign wperm[0] = s0_wr.perm_x;
   assign wperm[1] = s0_wr.perm_y;
   assign wperm[2] = s0_wr.perm_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_idx[a] = s0_coord[a][CoordFrac +: IdxW];
         hi_idx[a] = lo_idx[a] + 1'b1;
      end
      for (int n = 0; n < 8; n++) begin
         corner_idx[n] = to_idx((n[0] ? perm_hi_ff[0] : perm_lo_ff[0])
                              ^ (n[1] ? perm_hi_ff[1] : perm_lo_ff[1])
                              ^ (n[2] ? perm_hi_ff[2] : perm_lo_ff[2]));
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (s0_wr.perm_wr) begin
            perm_mem_ff[a][widx] <= wperm[a];
         end
         perm_lo_ff[a] <= perm_mem_ff[a][lo_idx[a]];
         perm_hi_ff[a] <= perm_mem_ff[a][hi_idx[a]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         gwr_ff <= 1'b0;
      end else begin
         v1_ff <= s0_valid;
         v2_ff <= v1_ff;
         gwr_ff <= s0_wr.grad_wr;
      end
      ctl1_ff <= s0_ctl;
      ctl2_ff <= ctl1_ff;
      gidx_ff <= widx;
      gdata_ff <= {s0_wr.grad_z, s0_wr.grad_y, s0_wr.grad_x};
      for (int a = 0; a < 3; a++) begin
         frac1_ff[a] <= s0_coord[a][CoordFrac-1:0];
         f2_ff[a] <= 16'((32'(s0_coord[a][CoordFrac-1:0])
                        * 32'(s0_coord[a][CoordFrac-1:0])) >> CoordFrac);
         frac2_ff[a] <= frac1_ff[a];
         fade_ff[a] <= 16'((34'(f2_ff[a]) * (34'(18'd196608)
                        - 34'({frac1_ff[a], 1'b0}))) >> CoordFrac);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_copy
      logic [47:0] grad_mem_ff [TABLE_SIZE];
      always_ff @(posedge clock) begin
         if (gwr_ff) begin
            grad_mem_ff[gidx_ff] <= gdata_ff;
         end
         grad_ff[2*g] <= grad_mem_ff[corner_idx[2*g]];
         grad_ff[2*g+1] <= grad_mem_ff[corner_idx[2*g+1]];
      end
   end

   assign s2_valid = v2_ff;
   assign s2_ctl = ctl2_ff;
   assign s2_frac = frac2_ff;
   assign s2_fade = fade_ff;
   assign s2_grad = grad_ff;
endmodule
`default_nettype wire

// File: design/gnt_blend.sv
// corner dot products, per-axis fade weighting and corner sum
`timescale 1ns / 1ps
`default_nettype none
module gnt_blend import gnt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            s2_valid,
   input  wire ctl_type         s2_ctl,
   input  wire logic [2:0][15:0] s2_frac,
   input  wire logic [2:0][15:0] s2_fade,
   input  wire logic [7:0][47:0] s2_grad,
   output logic                 s7_valid,
   output ctl_type              s7_ctl,
   output logic signed [23:0]   s7_noise
);
   logic               v_ff [5];
   ctl_type            ctl_ff [4];
   logic signed [20:0] t_ff [4][8];
   logic [16:0]        wlo_ff [4][3];
   logic [16:0]        whi_ff [4][3];
   logic signed [34:0] dot [8];
   logic signed [20:0] sum_terms [8];
   logic               v7_ff;
   ctl_type            ctl7_ff;
   logic signed [23:0] noise_ff, noise_sum;

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         dot[n] = '0;
         for (int a = 0; a < 3; a++) begin
            dot[n] = dot[n] + 35'($signed(s2_grad[n][16*a +: 16]))
                   * 35'($signed({n[a], s2_frac[a]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 8; n++) begin
         t_ff[0][n] <= dot[n][34:14];
      end
      for (int a = 0; a < 3; a++) begin
         whi_ff[0][a] <= {1'b0, s2_fade[a]};
         wlo_ff[0][a] <= 17'h10000 - {1'b0, s2_fade[a]};
      end
      ctl_ff[0] <= s2_ctl;
   end

   for (genvar k = 1; k < 4; k++) begin : g_weight
      logic signed [38:0] prod [8];
      always_comb begin
         for (int n = 0; n < 8; n++) begin
            prod[n] = 39'(t_ff[k-1][n]) * 39'($signed({1'b0,
                      (n[k-1] ? whi_ff[k-1][k-1] : wlo_ff[k-1][k-1])}));
         end
      end
      always_ff @(posedge clock) begin
         for (int n = 0; n < 8; n++) begin
            t_ff[k][n] <= prod[n][36:16];
         end
         wlo_ff[k] <= wlo_ff[k-1];
         whi_ff[k] <= whi_ff[k-1];
         ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   always_comb begin
      for (int n = 0; n < 8; n++) begin
         sum_terms[n] = t_ff[3][n];
      end
      noise_sum = '0;
      for (int n = 0; n < 8; n++) begin
         noise_sum = noise_sum + 24'(sum_terms[n]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            v_ff[k] <= 1'b0;
         end
         v7_ff <= 1'b0;
      end else begin
         v_ff[0] <= s2_valid;
         for (int k = 1; k < 5; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         v7_ff <= v_ff[3];
      end
      ctl7_ff <= ctl_ff[3];
      noise_ff <= noise_sum;
   end

   assign s7_valid = v7_ff & v_ff[4];
   assign s7_ctl = ctl7_ff;
   assign s7_noise = noise_ff;
endmodule
`default_nettype wire

// File: design/gnt_accum.sv
// octave accumulation, magnitude, scaling and saturation
`timescale 1ns / 1ps
`default_nettype none
module gnt_accum import gnt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               s7_valid,
   input  wire ctl_type            s7_ctl,
   input  wire logic signed [23:0] s7_noise,
   output logic                    rsp_strobe,
   output logic signed [19:0]      rsp_noise_value
);
   logic signed [42:0] acc_ff, fin_ff, term, total, mag;
   logic signed [27:0] scaled;
   logic               fin_valid_ff, fin_abs_ff, strobe_ff;
   logic signed [19:0] value_ff, value_in;

   always_comb begin
      term = s7_ctl.zero ? 43'sd0 : (43'(s7_noise) <<< s7_ctl.shift);
      total = (s7_ctl.first ? 43'sd0 : acc_ff) + term;
      mag = (fin_abs_ff && fin_ff < 0) ? -fin_ff : fin_ff;
      scaled = 28'(mag >>> (CoordFrac - 1));
      if (scaled > 28'sd524287) begin
         value_in = 20'sd524287;
      end else if (scaled < -28'sd524288) begin
         value_in = -20'sd524288;
      end else begin
         value_in = scaled[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         fin_valid_ff <= s7_valid & s7_ctl.last;
         strobe_ff <= fin_valid_ff;
      end
      if (s7_valid) begin
         acc_ff <= total;
      end
      if (s7_valid & s7_ctl.last) begin
         fin_ff <= total;
         fin_abs_ff <= s7_ctl.absval;
      end
      value_ff <= value_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_noise_value = value_ff;
endmodule
`default_nettype wire

// File: design/gradient_noise_turbulence_top.sv
// top level of the 3d gradient noise and turbulence engine
//  channel   | handshake             | payload
//  request   | start / busy          | req_command, req_coord_*, req_table_index,
//            |                       | req_grad_*, req_perm_*
//  result    | rsp_strobe (1 cycle)  | rsp_noise_value
//  config    | apb psel/penable      | octave_count at byte 0
// one pass evaluates all eight corners of one octave and can issue every cycle
// noise issues one pass, loads one table write, turbulence max(1, octave_count) passes
// the octave sequencer holds busy while it reissues the shifted point
// synchronous active-high reset clears control, tables hold until written
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_turbulence_top import gnt_pkg::*; #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic [7:0]         req_table_index,
   input  wire logic signed [15:0] req_grad_x,
   input  wire logic signed [15:0] req_grad_y,
   input  wire logic signed [15:0] req_grad_z,
   input  wire logic [7:0]         req_perm_x,
   input  wire logic [7:0]         req_perm_y,
   input  wire logic [7:0]         req_perm_z,
   output logic                    rsp_strobe,
   output logic signed [19:0]      rsp_noise_value,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   logic [3:0] octave_ff;
   logic             s0_valid, s2_valid, s7_valid;
   ctl_type          s0_ctl, s2_ctl, s7_ctl;
   logic [2:0][31:0] s0_coord;
   wr_type           s0_wr;
   logic [2:0][15:0] s2_frac, s2_fade;
   logic [7:0][47:0] s2_grad;
   logic signed [23:0] s7_noise;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_OCTAVE) ? {28'd0, octave_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= OCTAVE_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_OCTAVE) begin
         octave_ff <= pwdata[3:0];
      end
   end

   gnt_issue u_issue (
      .clock(clock), .reset(reset), .start(start), .command(req_command),
      .coord_x(req_coord_x), .coord_y(req_coord_y), .coord_z(req_coord_z),
      .table_index(req_table_index), .grad_x(req_grad_x), .grad_y(req_grad_y),
      .grad_z(req_grad_z), .perm_x(req_perm_x), .perm_y(req_perm_y),
      .perm_z(req_perm_z), .octave_count(octave_ff), .busy(busy),
      .s0_valid(s0_valid), .s0_ctl(s0_ctl), .s0_coord(s0_coord), .s0_wr(s0_wr)
   );

   gnt_fetch #(.TABLE_SIZE(TABLE_SIZE)) u_fetch (
      .clock(clock), .reset(reset), .s0_valid(s0_valid), .s0_ctl(s0_ctl),
      .s0_coord(s0_coord), .s0_wr(s0_wr), .s2_valid(s2_valid), .s2_ctl(s2_ctl),
      .s2_frac(s2_frac), .s2_fade(s2_fade), .s2_grad(s2_grad)
   );

   gnt_blend u_blend (
      .clock(clock), .reset(reset), .s2_valid(s2_valid), .s2_ctl(s2_ctl),
      .s2_frac(s2_frac), .s2_fade(s2_fade), .s2_grad(s2_grad),
      .s7_valid(s7_valid), .s7_ctl(s7_ctl), .s7_noise(s7_noise)
   );

   gnt_accum u_accum (
      .clock(clock), .reset(reset), .s7_valid(s7_valid), .s7_ctl(s7_ctl),
      .s7_noise(s7_noise), .rsp_strobe(rsp_strobe), .rsp_noise_value(rsp_noise_value)
   );
endmodule
`default_nettype wire

// File: design/gnt_checker.sv
// port-level checks for the noise engine and their binding
`timescale 1ns / 1ps
`default_nettype none
module gnt_checker import gnt_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_command,
   input wire logic       rsp_strobe
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("strobe or busy right after reset");
   a_single_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != CMD_TURB) |=> !busy)
      else $error("busy after a single-pass item");
   a_busy_source: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !busy)
      else $error("busy rose without an item");
endmodule

bind gradient_noise_turbulence_top gnt_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_command(req_command), .rsp_strobe(rsp_strobe)
);
`default_nettype wire

// File: sim/gradient_noise_turbulence_top_tb.sv
// self-checking testbench for the gradient noise and turbulence engine
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_turbulence_top_tb;
   import gnt_pkg::*;

   localparam logic [2:0] OCTAVE_ADDR = 3'd0;
   localparam longint ONE = 64'sd1 <<< CoordFrac;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_NOISE;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic [7:0] req_table_index = '0;
   logic signed [15:0] req_grad_x = '0, req_grad_y = '0, req_grad_z = '0;
   logic [7:0] req_perm_x = '0, req_perm_y = '0, req_perm_z = '0;
   logic rsp_strobe;
   logic signed [19:0] rsp_noise_value;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gradient_noise_turbulence_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_table_index(req_table_index), .req_grad_x(req_grad_x),
      .req_grad_y(req_grad_y), .req_grad_z(req_grad_z),
      .req_perm_x(req_perm_x), .req_perm_y(req_perm_y), .req_perm_z(req_perm_z),
      .rsp_strobe(rsp_strobe), .rsp_noise_value(rsp_noise_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow state of the block
   logic signed [15:0] grad_shadow [3][256];
   logic [7:0] perm_shadow [3][256];
   logic [3:0] octave_shadow = OCTAVE_RESET;
   logic signed [19:0] expected_noise [$];
   int mismatches = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   function automatic longint noise_at(input logic [31:0] cx, input logic [31:0] cy,
                                       input logic [31:0] cz);
      logic [31:0] c [3];
      longint v, f2, dot, t, w, sum;
      longint base [3], frac [3], fade [3];
      int cor [3];
      int idx;
      c[0] = cx; c[1] = cy; c[2] = cz;
      sum = 0;
      for (int a = 0; a < 3; a++) begin
         v = longint'(signed'(c[a]));
         base[a] = v >>> CoordFrac;
         frac[a] = v & (ONE - 1);
         f2 = (frac[a] * frac[a]) >>> CoordFrac;
         fade[a] = (f2 * (3 * ONE - 2 * frac[a])) >>> CoordFrac;
      end
      for (int n = 0; n < 8; n++) begin
         cor[0] = (n >> 2) & 1; cor[1] = (n >> 1) & 1; cor[2] = n & 1;
         idx = 0;
         for (int a = 0; a < 3; a++)
            idx ^= perm_shadow[a][(base[a] + cor[a]) & 255];
         dot = 0;
         for (int a = 0; a < 3; a++)
            dot += longint'(grad_shadow[a][idx]) * (frac[a] - cor[a] * ONE);
         t = dot >>> GradFrac;
         for (int a = 0; a < 3; a++) begin
            w = cor[a] ? fade[a] : ONE - fade[a];
            t = (t * w) >>> CoordFrac;
         end
         sum += t;
      end
      return sum;
   endfunction

   function automatic logic signed [19:0] predict_noise(input logic [1:0] cmd,
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz);
      longint acc;
      acc = 0;
      if (cmd == CMD_NOISE) begin
         acc = noise_at(cx, cy, cz) * (64'sd1 <<< 15);
      end else begin
         for (int o = 0; o < octave_shadow; o++)
            acc += noise_at(cx << o, cy << o, cz << o) * (64'sd1 <<< (15 - o));
         if (acc < 0) acc = -acc;
      end
      acc = acc >>> (CoordFrac - 1);
      if (acc > 524287) acc = 524287;
      if (acc < -524288) acc = -524288;
      return acc[19:0];
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [31:0] cx,
      input logic [31:0] cy, input logic [31:0] cz, input logic [7:0] ti,
      input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] gz,
      input logic [7:0] px, input logic [7:0] py, input logic [7:0] pz);
      req_command <= cmd;
      req_coord_x <= cx; req_coord_y <= cy; req_coord_z <= cz;
      req_table_index <= ti;
      req_grad_x <= gx; req_grad_y <= gy; req_grad_z <= gz;
      req_perm_x <= px; req_perm_y <= py; req_perm_z <= pz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      case (cmd)
         CMD_LOAD_GRAD: begin
            grad_shadow[0][ti] = gx; grad_shadow[1][ti] = gy; grad_shadow[2][ti] = gz;
         end
         CMD_LOAD_PERM: begin
            perm_shadow[0][ti] = px; perm_shadow[1][ti] = py; perm_shadow[2][ti] = pz;
         end
         default: expected_noise.push_back(predict_noise(cmd, cx, cy, cz));
      endcase
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      stop_sending();
      wait (expected_noise.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_octaves(input logic [3:0] count);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= OCTAVE_ADDR;
      pwdata <= {8'($urandom_range(0, 255)), 24'h0} | 32'(count);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      octave_shadow = count;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h00ff_ffff);
         2: return -$urandom_range(0, 32'h00ff_ffff);
         default: return {{12{1'b0}}, 20'($urandom)} ^ {32{1'($urandom_range(1))}};
      endcase
   endfunction

   function automatic logic [15:0] rand_grad();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic test_table_fill();
      for (int n = 0; n < 256; n++)
         send_item(CMD_LOAD_PERM, 0, 0, 0, 8'(n), 0, 0, 0,
                   8'($urandom), 8'($urandom), 8'($urandom));
      for (int n = 0; n < 256; n++)
         send_item(CMD_LOAD_GRAD, 0, 0, 0, 8'(n), rand_grad(), rand_grad(), rand_grad(),
                   0, 0, 0);
   endtask

   task automatic test_directed();
      // gradient extremes and oversized entries
      send_item(CMD_LOAD_GRAD, 0, 0, 0, 8'd0, 16'sd16384, -16'sd16384, 16'sd16384, 0, 0, 0);
      send_item(CMD_LOAD_GRAD, 0, 0, 0, 8'd255, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0);
      send_item(CMD_LOAD_PERM, 0, 0, 0, 8'd255, 0, 0, 0, 8'hff, 8'h00, 8'hff);
      send_item(CMD_LOAD_PERM, 0, 0, 0, 8'd0, 0, 0, 0, 8'h00, 8'hff, 8'h00);
      send_item(CMD_NOISE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NOISE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NOISE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NOISE, 32'h0000_ffff, 32'h0000_8000, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NOISE, 32'hffff_ffff, 32'hfffe_8000, 32'h00ff_7fff, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_TURB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_TURB, 32'h7fff_ffff, 32'h8000_0000, 32'h4000_8000, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_TURB, 32'h00ff_c000, 32'hff00_4000, 32'h0000_2000, 0, 0, 0, 0, 0, 0, 0);
      write_octaves(4'd15);
      send_item(CMD_TURB, 32'h1234_5678, 32'hfedc_ba98, 32'h0f0f_f0f0, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_TURB, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001, 0, 0, 0, 0, 0, 0, 0);
      write_octaves(4'd0);
      send_item(CMD_TURB, 32'h1234_5678, 32'h0000_8000, 32'h0001_8000, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_NOISE, 32'h1234_5678, 32'h0000_8000, 32'h0001_8000, 0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int count, input int pct, input logic [3:0] octaves);
      logic [1:0] cmd;
      int pause_at;
      write_octaves(octaves);
      idle_pct = pct;
      pause_at = $urandom_range(1, count - 1);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(19))
            0, 1, 2: cmd = CMD_LOAD_GRAD;
            3, 4: cmd = CMD_LOAD_PERM;
            5, 6, 7, 8, 9, 10, 11, 12: cmd = CMD_NOISE;
            default: cmd = CMD_TURB;
         endcase
         send_item(cmd, rand_coord(), rand_coord(), rand_coord(), 8'($urandom),
                   rand_grad(), rand_grad(), rand_grad(),
                   8'($urandom), 8'($urandom), 8'($urandom));
         if (n == pause_at) begin
            stop_sending();
            wait (expected_noise.size() == 0);
         end
      end
      idle_pct = 0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_noise.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result noise_value=%0d", rsp_noise_value);
         end else begin
            if (rsp_noise_value !== expected_noise[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise_value mismatch: expected %0d actual %0d",
                           expected_noise[0], rsp_noise_value);
            end
            void'(expected_noise.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("gradient_noise_turbulence_top_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_directed();
      test_random(70, 0, 4'd7);
      test_random(70, 81, 4'd1);
      test_random(70, 0, 4'd15);
      test_random(70, 30, 4'($urandom_range(2, 14)));
      drain();
      if (mismatches == 0 && expected_noise.size() == 0)
         $display("gradient_noise_turbulence_top_tb OK");
      else
         $display("gradient_noise_turbulence_top_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
